// ----- design/kmrd_pkg.sv -----
// Shared constants and types of the key matrix row debouncer.
// No dependencies; imported by every module of the block.
package kmrd_pkg;

    // Matrix geometry
    localparam int ROWS       = 5;
    localparam int COLUMNS    = 16;
    localparam int FIELD_COLS = 16;
    localparam int LIVE_COLS  = (COLUMNS < FIELD_COLS) ? COLUMNS : FIELD_COLS;

    // Field widths
    localparam int ROW_W     = 3;
    localparam int COL_W     = FIELD_COLS;
    localparam int HOLD_W    = 8;
    localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd3;

    // Stream widths, padded to whole bytes
    localparam int S_FIELDS_W = ROW_W + COL_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = ROW_W + 3 * COL_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // Control shared by the column lanes and the merge stage
    typedef struct packed {
        logic                 wr;
        logic                 row_ok;
        logic [ROW_IDX_W-1:0] row;
        logic [HOLD_W-1:0]    hold;
    } kmrd_lane_ctl_t;

    // Result fields, row in the lowest bits
    typedef struct packed {
        logic [COL_W-1:0] changed;
        logic [COL_W-1:0] previous;
        logic [COL_W-1:0] stable;
        logic [ROW_W-1:0] row;
    } kmrd_result_t;

endpackage

// ----- design/kmrd_lane.sv -----
// One column lane: hold countdowns of this column for every row.
// Depends on kmrd_pkg.
module kmrd_lane
    import kmrd_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  kmrd_lane_ctl_t ctl,
    input  logic           raw_bit,
    input  logic           prev_bit,
    output logic           next_bit
);

    logic [HOLD_W-1:0] cnt_reg [ROWS];
    logic [HOLD_W-1:0] cnt_cur;
    logic [HOLD_W-1:0] cnt_next;
    logic              take;
    logic              change;

    // Key follows raw input only once its countdown has run out
    always_comb begin
        cnt_cur  = cnt_reg[ctl.row];
        take     = (cnt_cur == '0);
        next_bit = take ? raw_bit : prev_bit;
        change   = next_bit ^ prev_bit;
        if (change) begin
            cnt_next = ctl.hold;
        end else if (take) begin
            cnt_next = '0;
        end else begin
            cnt_next = cnt_cur - 1'b1;
        end
    end

    // Countdown storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < ROWS; r++) begin
                cnt_reg[r] <= '0;
            end
        end else if (ctl.wr) begin
            cnt_reg[ctl.row] <= cnt_next;
        end
    end

endmodule

// ----- design/kmrd_merge.sv -----
// Merge stage: per-row stable words, gathers lane bits into a result.
// Depends on kmrd_pkg.
module kmrd_merge
    import kmrd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  kmrd_lane_ctl_t   ctl,
    input  logic [ROW_W-1:0] row_index,
    input  logic [COL_W-1:0] next_word,
    output logic [COL_W-1:0] prev_word,
    output kmrd_result_t     result
);

    logic [COL_W-1:0] stable_reg [ROWS];
    logic [COL_W-1:0] stable_word;

    // Current stable word of the requested row; zero off the matrix
    always_comb begin
        prev_word      = ctl.row_ok ? stable_reg[ctl.row] : '0;
        stable_word    = ctl.row_ok ? next_word : '0;
        result.row      = row_index;
        result.stable   = stable_word;
        result.previous = prev_word;
        result.changed  = stable_word ^ prev_word;
    end

    // Stable word storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < ROWS; r++) begin
                stable_reg[r] <= '0;
            end
        end else if (ctl.wr) begin
            stable_reg[ctl.row] <= next_word;
        end
    end

endmodule

// ----- design/key_matrix_row_debouncer_top.sv -----
// Top level of the key matrix row debouncer: column lanes, merge, output skid.
// Depends on kmrd_pkg, kmrd_lane and kmrd_merge.
//
// Usage:
//   s_ channel: one request per row scan, carrying the row index and the raw
//   column sample of that row. m_ channel: one result per request, carrying
//   the row, its new debounced columns, the previous ones and the changed bits.
//   cfg_we / cfg_wdata write the hold setting (scans a key ignores raw input
//   after a change); write it only while no request is in flight.
// Each result is registered on accept, into the skid register under a stall.
// Throughput: one request per cycle while s_tready is high; all sixteen column
//   lanes update their countdowns on accept, so a row can be rescanned at once.
// Stall: a two-entry output (result register plus skid register) keeps
//   s_tready high while one result waits; s_tready drops only when both hold
//   results, and returns as soon as m_tready takes one.
// Reset: aresetn low clears all stable words and countdowns, sets the hold
//   setting to 3 and empties the output; no clearing pass is needed.
// Rows beyond the matrix change nothing and return all-zero column fields.
module key_matrix_row_debouncer_top
    import kmrd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // row_index, raw_columns
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // row_out, stable_columns,
                                           // previous_columns, changed_columns
    input  logic                cfg_we,
    input  logic [HOLD_W-1:0]   cfg_wdata
);

    logic [HOLD_W-1:0]   hold_reg;
    logic                accept;
    logic [ROW_W-1:0]    row_index;
    logic [COL_W-1:0]    raw_columns;
    logic                row_ok;
    kmrd_lane_ctl_t      ctl;
    logic [COL_W-1:0]    prev_word;
    logic [COL_W-1:0]    next_word;
    kmrd_result_t        result;
    logic [M_DATA_W-1:0] result_data;

    logic                out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic                skid_valid_reg, skid_valid_next;
    logic [M_DATA_W-1:0] skid_data_reg, skid_data_next;

    // Hold setting
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= HOLD_RESET;
        end else if (cfg_we) begin
            hold_reg <= cfg_wdata;
        end
    end

    // Request decode and lane control
    always_comb begin
        row_index   = s_tdata[ROW_W-1:0];
        raw_columns = s_tdata[ROW_W +: COL_W];
        accept      = s_tvalid && s_tready;
        row_ok      = ({29'd0, row_index} < 32'(ROWS));
        ctl.wr      = accept && row_ok;
        ctl.row_ok  = row_ok;
        ctl.row     = row_ok ? row_index[ROW_IDX_W-1:0] : '0;
        ctl.hold    = hold_reg;
    end

    // One lane per live column; columns past the matrix read as zero
    for (genvar c = 0; c < COL_W; c++) begin : g_col
        if (c < LIVE_COLS) begin : g_live
            kmrd_lane u_lane (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (ctl),
                .raw_bit  (raw_columns[c]),
                .prev_bit (prev_word[c]),
                .next_bit (next_word[c])
            );
        end else begin : g_dead
            assign next_word[c] = 1'b0;
        end
    end

    kmrd_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .row_index (row_index),
        .next_word (next_word),
        .prev_word (prev_word),
        .result    (result)
    );

    assign result_data = {{(M_DATA_W - M_FIELDS_W){1'b0}}, result};

    // Output register with skid entry
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && !m_tready) begin
            if (accept) begin
                skid_valid_next = 1'b1;
                skid_data_next  = result_data;
            end
        end else if (skid_valid_reg) begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end else begin
            out_valid_next = accept;
            out_data_next  = result_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- design/kmrd_checker.sv -----
// Port-level checks of the key matrix row debouncer, bound to the top level.
// Depends on kmrd_pkg and key_matrix_row_debouncer_top.
module kmrd_checker
    import kmrd_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Changed bits agree with new and previous words
    a_changed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[ROW_W + 2*COL_W +: COL_W] ==
                      (m_tdata[ROW_W +: COL_W] ^ m_tdata[ROW_W + COL_W +: COL_W])))
        else $error("changed bits mismatch");

    // Rows off the matrix return zero column fields
    a_bad_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ({29'd0, m_tdata[ROW_W-1:0]} >= 32'(ROWS))
        |-> (m_tdata[ROW_W +: 3*COL_W] == '0))
        else $error("out of range row returned data");

    // Reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind key_matrix_row_debouncer_top kmrd_checker u_kmrd_checker (.*);

// ----- verif/tb_top.sv -----
// Self-checking testbench for key_matrix_row_debouncer_top: directed and random row scans.
// A scoreboard class predicts each result; the hold setting is changed between phases.
// Depends on kmrd_pkg and the debouncer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kmrd_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // Predicts the debounced row words and keeps the results still owed by the block
    class debounce_book;
        logic [COL_W-1:0]  row_word [ROWS];
        logic [HOLD_W-1:0] countdown [ROWS][COLUMNS];
        logic [HOLD_W-1:0] hold_setting;
        kmrd_result_t      owed_q[$];
        int                errors;

        function new();
            for (int r = 0; r < ROWS; r++) begin
                row_word[r] = '0;
                for (int c = 0; c < COLUMNS; c++) begin
                    countdown[r][c] = '0;
                end
            end
            hold_setting = HOLD_RESET;
            errors = 0;
        endfunction

        // Accepted request: update the row and queue the result it must produce
        function void note_request(logic [ROW_W-1:0] row, logic [COL_W-1:0] raw);
            kmrd_result_t     res;
            logic [COL_W-1:0] take;
            logic [COL_W-1:0] live;
            logic [COL_W-1:0] prev;
            logic [COL_W-1:0] nxt;
            res = '0;
            res.row = row;
            if (row < ROWS) begin
                take = '0;
                live = '0;
                prev = row_word[row];
                for (int c = 0; c < LIVE_COLS; c++) begin
                    live[c] = 1'b1;
                    if (countdown[row][c] != 0) begin
                        countdown[row][c] = countdown[row][c] - 1'b1;
                    end else begin
                        take[c] = 1'b1;
                    end
                end
                nxt = ((raw & take) | (prev & ~take)) & live;
                for (int c = 0; c < LIVE_COLS; c++) begin
                    if (nxt[c] != prev[c]) begin
                        countdown[row][c] = hold_setting;
                    end
                end
                row_word[row] = nxt;
                res.stable   = nxt;
                res.previous = prev;
                res.changed  = nxt ^ prev;
            end
            owed_q.push_back(res);
        endfunction

        // Accepted result: compare with the oldest owed one
        function void check_result(logic [M_DATA_W-1:0] data);
            kmrd_result_t got;
            kmrd_result_t want;
            got = data[M_FIELDS_W-1:0];
            if (owed_q.size() == 0) begin
                $error("result with nothing owed: row_out %0d", got.row);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.row !== want.row) begin
                $error("row_out expected %0d actual %0d", want.row, got.row);
                errors++;
            end
            if (got.stable !== want.stable) begin
                $error("stable_columns expected %h actual %h", want.stable, got.stable);
                errors++;
            end
            if (got.previous !== want.previous) begin
                $error("previous_columns expected %h actual %h", want.previous, got.previous);
                errors++;
            end
            if (got.changed !== want.changed) begin
                $error("changed_columns expected %h actual %h", want.changed, got.changed);
                errors++;
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;    // row_index, raw_columns
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // row_out, stable, previous, changed columns
    logic                cfg_we = 1'b0;
    logic [HOLD_W-1:0]   cfg_wdata = '0;

    debounce_book     book = new();
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    logic [COL_W-1:0] last_raw [8];

    key_matrix_row_debouncer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 0;
    end

    // Result side: check on handshake, then pick the next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            book.check_result(m_tdata);
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard stop in case the block hangs
    initial begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

    task automatic set_idling(idle_mode_t mode);
        send_idle_pct  = (mode == IDLE_SENDER || mode == IDLE_BOTH) ?
                         ((mode == IDLE_BOTH) ? 10 : 84) : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER || mode == IDLE_BOTH) ?
                         ((mode == IDLE_BOTH) ? 10 : 84) : 0;
    endtask

    // One request: optional idle gap, then hold valid until accepted
    task automatic scan_row(logic [ROW_W-1:0] row, logic [COL_W-1:0] raw);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - S_FIELDS_W){1'b0}}, raw, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        book.note_request(row, raw);
        last_raw[row] = raw;
    endtask

    // Stop sending and wait until every owed result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (book.owed_q.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_hold(logic [HOLD_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        book.hold_setting = value;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Random scans; bouncy samples flip one or many bits of the row's last sample.
    // With focus set, nearly every scan hits row 3 so long holds can run out.
    task automatic random_scans(int count, bit focus);
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] raw;
        for (int i = 0; i < count; i++) begin
            if (focus && $urandom_range(99) < 96) begin
                row = 3'd3;
            end else if ($urandom_range(9) == 0) begin
                row = ROW_W'($urandom_range(7, ROWS));
            end else begin
                row = ROW_W'($urandom_range(ROWS - 1, 0));
            end
            case ($urandom_range(9))
                0, 1, 2, 3: raw = COL_W'($urandom());
                4, 5, 6:    raw = last_raw[row] ^ (16'd1 << $urandom_range(15));
                7:          raw = last_raw[row] ^ COL_W'($urandom() ^ $urandom());
                8:          raw = '1;
                default:    raw = '0;
            endcase
            scan_row(row, raw);
        end
    endtask

    initial begin
        for (int r = 0; r < 8; r++) last_raw[r] = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: hold at reset value, a press held through its countdown
        set_idling(IDLE_NONE);
        scan_row(3'd0, 16'hFFFF);
        scan_row(3'd0, 16'h0000);
        scan_row(3'd0, 16'h0000);
        scan_row(3'd0, 16'h0000);
        scan_row(3'd0, 16'h0000);
        scan_row(3'd0, 16'h0000);
        scan_row(3'd4, 16'hFFFF);
        scan_row(3'd4, 16'hAAAA);
        scan_row(3'd1, 16'h8001);
        // Rows past the matrix change nothing
        scan_row(3'd5, 16'hFFFF);
        scan_row(3'd6, 16'hFFFF);
        scan_row(3'd7, 16'h5555);
        scan_row(3'd1, 16'h7FFE);

        // Directed: hold of zero, keys follow raw on every scan
        write_hold(8'd0);
        scan_row(3'd2, 16'h5555);
        scan_row(3'd2, 16'hAAAA);
        scan_row(3'd2, 16'hFFFF);
        scan_row(3'd2, 16'h0000);
        scan_row(3'd4, 16'h5555);

        // Random phases over several hold settings and idling patterns
        random_scans(110, 1'b0);
        write_hold(8'd1);
        set_idling(IDLE_SENDER);
        random_scans(110, 1'b0);
        write_hold(8'd255);
        set_idling(IDLE_RECEIVER);
        random_scans(300, 1'b1);
        write_hold(HOLD_W'($urandom_range(254, 2)));
        set_idling(IDLE_BOTH);
        random_scans(120, 1'b0);
        write_hold(8'd2);
        set_idling(IDLE_NONE);
        random_scans(40, 1'b0);
        set_idling(IDLE_RECEIVER);
        random_scans(70, 1'b0);

        settle();
        repeat (10) @(posedge aclk);
        if (book.errors == 0 && book.owed_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
